[hw/rtl/date_to_day_count_macros.svh]
// ----------------------------------------------------------------------------
// date_to_day_count assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DATE_TO_DAY_COUNT_MACROS_SVH
`define DATE_TO_DAY_COUNT_MACROS_SVH

// same-cycle implication
`define DTDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// delayed implication, consequent checked after the antecedent
`define DTDC_ASSERT_DLY2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

[hw/rtl/dtdc_pkg.sv]
// ----------------------------------------------------------------------------
// dtdc_pkg
// Payload types and calendar tables for the date to day count block.
// ----------------------------------------------------------------------------
package dtdc_pkg;

  // one input date
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } dtdc_in_t;

  // one result
  typedef struct packed {
    logic        valid_res;
    logic [8:0]  day_of_year;
    logic [19:0] serial_day;
    logic [2:0]  weekday;
  } dtdc_out_t;

  // reciprocal for division by 100, exact for inputs below 43699
  localparam int unsigned DIV100_MUL = 5243;

  // days in a month, zero for month codes that mean nothing
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days before the first of a month in a common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // month term of the weekday formula, floor(23 * m / 9)
  function automatic logic [4:0] month_term(input logic [3:0] m);
    logic [4:0] t;
    case (m)
      4'd1:    t = 5'd2;
      4'd2:    t = 5'd5;
      4'd3:    t = 5'd7;
      4'd4:    t = 5'd10;
      4'd5:    t = 5'd12;
      4'd6:    t = 5'd15;
      4'd7:    t = 5'd17;
      4'd8:    t = 5'd20;
      4'd9:    t = 5'd23;
      4'd10:   t = 5'd25;
      4'd11:   t = 5'd28;
      4'd12:   t = 5'd30;
      default: t = 5'd0;
    endcase
    return t;
  endfunction

  // year divided by 100 through a reciprocal multiply
  function automatic logic [5:0] div100(input logic [11:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'(DIV100_MUL);
    return p[24:19];
  endfunction

  // remainder by 7: fold octal digits, since 8 is 1 mod 7
  function automatic logic [2:0] mod7(input logic [12:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[12]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

endpackage

[hw/rtl/date_to_day_count.sv]
// ----------------------------------------------------------------------------
// date_to_day_count
// A date accepted into the input register is answered from the result register
// by a result strobe that is high for one cycle.
// Throughput: one date per clock; busy is low whenever reset is released.
// The input register and the result register frame one pass of table lookups,
// two reciprocal multiplies and the day sums; the receiver cannot stall.
// Reset (rst_n low, synchronous) clears both valid stages and holds busy high.
// ----------------------------------------------------------------------------
module date_to_day_count
  import dtdc_pkg::*;
#(
  parameter int BASE_YEAR = 1900,
  parameter int MAX_YEAR  = 4095
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  dtdc_in_t  in_data,
  output logic      busy,
  output logic      out_valid,
  output dtdc_out_t out_data
);

  localparam logic [11:0] BASE_Y     = 12'(BASE_YEAR);
  localparam logic [11:0] MAX_Y      = 12'(MAX_YEAR);
  localparam int          BASE_LEAPS = (BASE_YEAR - 1) / 4 - (BASE_YEAR - 1) / 100
                                     + (BASE_YEAR - 1) / 400;
  localparam logic [20:0] BASE_LEAPS_W = 21'(BASE_LEAPS);

  logic      in_vld_r;
  dtdc_in_t  in_r;
  logic      out_valid_r;
  dtdc_out_t out_r;
  dtdc_out_t out_nxt;

  logic [4:0]  d;
  logic [3:0]  m;
  logic [11:0] y;
  logic [11:0] ym1;
  logic [5:0]  qa;
  logic [5:0]  qb;
  logic [5:0]  qyy;
  logic [9:0]  yy4;
  logic        cent;
  logic        leap;
  logic        early;
  logic        ok;
  logic [4:0]  mlen;
  logic [8:0]  doy;
  logic [9:0]  lym1;
  logic [12:0] wsum;
  logic [20:0] serial;

  // no accept while in reset
  assign busy = !rst_n;

  // transfer valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_vld_r    <= start && !busy;
      out_valid_r <= in_vld_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
    out_r <= out_nxt;
  end

  // leap year, century and date validity detection
  always_comb begin
    d     = in_r.day;
    m     = in_r.month;
    y     = in_r.year;
    ym1   = y - 12'd1;
    qa    = div100(y);
    qb    = div100(ym1);
    // the quotient steps exactly when the year is a multiple of 100
    cent  = (qa != qb);
    leap  = (y[1:0] == 2'b00) && (!cent || (qa[1:0] == 2'b00));
    early = (m < 4'd3);
    mlen  = month_len(m, leap);
    ok    = (y >= BASE_Y) && (y <= MAX_Y) && (m != 4'd0) && (m <= 4'd12) &&
            (d != 5'd0) && (d <= mlen);
  end

  // day of year and serial count
  always_comb begin
    doy    = 9'(d) + days_before(m) + ((leap && !early) ? 9'd1 : 9'd0);
    lym1   = 10'(ym1[11:2]) - 10'(qb) + 10'(qb[5:2]);
    serial = 21'(doy) + 21'(y - BASE_Y) * 21'd365 + 21'(lym1) - BASE_LEAPS_W;
  end

  // weekday, Sunday is zero
  always_comb begin
    qyy  = early ? qb : qa;
    yy4  = early ? ym1[11:2] : y[11:2];
    wsum = 13'(month_term(m)) + 13'(d) + 13'(y) - (early ? 13'd0 : 13'd2) + 13'd4 +
           13'(yy4) - 13'(qyy) + 13'(qyy[5:2]);
  end

  // result, zeroed for an invalid date
  always_comb begin
    if (ok) begin
      out_nxt.valid_res   = 1'b1;
      out_nxt.day_of_year = doy;
      out_nxt.serial_day  = serial[19:0];
      out_nxt.weekday     = mod7(wsum);
    end else begin
      out_nxt = '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hw/rtl/dtdc_checker.sv]
// ----------------------------------------------------------------------------
// dtdc_checker
// Port-level checks on result timing and result contents, bound to the top.
// ----------------------------------------------------------------------------
`include "date_to_day_count_macros.svh"

module dtdc_checker
  import dtdc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input dtdc_out_t out_data
);

  logic in_xfer;
  logic valid_in_range;
  logic invalid_is_zero;

  // input transfer and result field summaries
  assign in_xfer         = start && !busy;
  assign valid_in_range  = (out_data.day_of_year != 9'd0) &&
                           (out_data.day_of_year <= 9'd366) &&
                           (out_data.serial_day != 20'd0) && (out_data.weekday <= 3'd6);
  assign invalid_is_zero = (out_data.day_of_year == 9'd0) &&
                           (out_data.serial_day == 20'd0) && (out_data.weekday == 3'd0);

  // every transfer in gives a later result strobe
  `DTDC_ASSERT_DLY2(a_result_follows, in_xfer, out_valid, "missing result")

  // no result strobe without an earlier transfer
  `DTDC_ASSERT_IMP(a_no_spurious, out_valid, $past(in_xfer, 2), "spurious result")

  // a valid date carries an in-range ordinal, count and weekday
  `DTDC_ASSERT_IMP(a_valid_ranges, out_valid && out_data.valid_res, valid_in_range, "valid result out of range")

  // an invalid date carries zeros
  `DTDC_ASSERT_IMP(a_invalid_zero, out_valid && !out_data.valid_res, invalid_is_zero, "invalid result not zero")

endmodule

bind date_to_day_count dtdc_checker u_dtdc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
